// ===== sv/assert_macros.svh =====
// Assertion macros shared by the allocator RTL.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define FFA_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

// Same-cycle implication.
`define FFA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define FFA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/ffa_pkg.sv =====
// Shared types and codes of the first-fit extent allocator.
// No dependencies; used by ffa_alu, ffa_ctrl, the top level and the bench.
`default_nettype none

package ffa_pkg;

	localparam int ADDR_W = 32;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [2:0] status_t;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam status_t ST_OK      = 3'd0;
	localparam status_t ST_NOSPACE = 3'd1;
	localparam status_t ST_ZERO    = 3'd2;
	localparam status_t ST_FULL    = 3'd3;
	localparam status_t ST_IGNORED = 3'd4;

	// One free extent as stored in the table RAM
	typedef struct packed {
		addr_t start;
		addr_t len;
	} extent_t;

	// Operand select for the shared adder
	typedef struct packed {
		addr_t a;
		addr_t b;
		logic  sub;
	} alu_req_t;

	// Heap registers plus a pulse on any register write
	typedef struct packed {
		addr_t heap_base;
		addr_t heap_size;
		logic  rebuild;
	} cfg_t;

endpackage

`default_nettype wire

// ===== sv/ffa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ffa_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== sv/ffa_alu.sv =====
// Shared 33-bit adder/subtracter of the allocator.
// Depends on ffa_pkg.
`default_nettype none

module ffa_alu (
	input  wire ffa_pkg::alu_req_t req,
	output logic [ffa_pkg::ADDR_W:0] sum
);
	import ffa_pkg::*;

	addr_t b_op;

	// sum[ADDR_W] is the carry on add, and "a >= b" on subtract
	assign b_op = req.sub ? ~req.b : req.b;
	assign sum  = {1'b0, req.a} + {1'b0, b_op} + {{ADDR_W{1'b0}}, req.sub};

endmodule

`default_nettype wire

// ===== sv/ffa_ctrl.sv =====
// Sequencer of the allocator: table scans, merges, shifts, result register.
// Depends on ffa_pkg and assert_macros.svh; drives ffa_alu and ffa_ram.
`default_nettype none
`include "assert_macros.svh"

module ffa_ctrl #(
	parameter int MAX_EXTENTS = 16,
	localparam int IW = $clog2(MAX_EXTENTS),
	localparam int CW = $clog2(MAX_EXTENTS + 1)
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire ffa_pkg::cfg_t       cfg,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic                op,
	input  wire ffa_pkg::addr_t      req_size,
	input  wire ffa_pkg::addr_t      block_addr,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output ffa_pkg::addr_t           grant_addr,
	output ffa_pkg::status_t         status,
	output ffa_pkg::alu_req_t        alu_req,
	input  wire logic [ffa_pkg::ADDR_W:0] alu_sum,
	output logic                     ram_we,
	output logic [IW-1:0]            ram_waddr,
	output ffa_pkg::extent_t         ram_wdata,
	output logic [IW-1:0]            ram_raddr,
	input  wire ffa_pkg::extent_t    ram_rdata
);
	import ffa_pkg::*;

	typedef enum logic [13:0] {
		S_REBUILD = 14'b00000000000001,
		S_IDLE    = 14'b00000000000010,
		S_ASCAN   = 14'b00000000000100,
		S_AUPD    = 14'b00000000001000,
		S_FCHK    = 14'b00000000010000,
		S_FSCAN   = 14'b00000000100000,
		S_FJOIN   = 14'b00000001000000,
		S_FMRG    = 14'b00000010000000,
		S_FMRG2   = 14'b00000100000000,
		S_SHIFT   = 14'b00001000000000,
		S_UPRD    = 14'b00010000000000,
		S_UPWR    = 14'b00100000000000,
		S_INS     = 14'b01000000000000,
		S_RESP    = 14'b10000000000000
	} state_t;

	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_EXTENTS);

	state_t        state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [CW-1:0] idx_q, idx_d;
	logic [CW-1:0] pos_q, pos_d;
	logic          op_q, op_d;
	addr_t         size_q, size_d;
	addr_t         addr_q, addr_d;
	addr_t         end_q, end_d;
	addr_t         acc_q, acc_d;
	extent_t       prev_q, prev_d;
	extent_t       cur_q, cur_d;
	logic          jlo_q, jlo_d;
	logic          jhi_q, jhi_d;
	addr_t         res_grant_q, res_grant_d;
	status_t       res_status_q, res_status_d;
	logic          out_valid_q;
	addr_t         out_grant_q;
	status_t       out_status_q;

	logic [CW-1:0] idx_p1, idx_p2, idx_m1, pos_p1, pos_m1, cnt_m1;
	addr_t         heap_len;
	logic          load_out;

	assign idx_p1 = idx_q + CW'(1);
	assign idx_p2 = idx_q + CW'(2);
	assign idx_m1 = idx_q - CW'(1);
	assign pos_p1 = pos_q + CW'(1);
	assign pos_m1 = pos_q - CW'(1);
	assign cnt_m1 = cnt_q - CW'(1);

	// heap clipped at the top of the address space
	assign heap_len = alu_sum[ADDR_W] ? ~cfg.heap_base : cfg.heap_size;

	assign in_ready   = (state_q == S_IDLE);
	assign load_out   = (state_q == S_RESP) && (!out_valid_q || out_ready);
	assign out_valid  = out_valid_q;
	assign grant_addr = out_grant_q;
	assign status     = out_status_q;

	always_comb begin
		state_d      = state_q;
		cnt_d        = cnt_q;
		idx_d        = idx_q;
		pos_d        = pos_q;
		op_d         = op_q;
		size_d       = size_q;
		addr_d       = addr_q;
		end_d        = end_q;
		acc_d        = acc_q;
		prev_d       = prev_q;
		cur_d        = cur_q;
		jlo_d        = jlo_q;
		jhi_d        = jhi_q;
		res_grant_d  = res_grant_q;
		res_status_d = res_status_q;
		alu_req      = '{a: '0, b: '0, sub: 1'b0};
		ram_we       = 1'b0;
		ram_waddr    = idx_q[IW-1:0];
		ram_wdata    = '0;
		ram_raddr    = idx_p1[IW-1:0];

		unique case (state_q)
			S_REBUILD: begin
				alu_req   = '{a: cfg.heap_base, b: cfg.heap_size, sub: 1'b0};
				ram_we    = 1'b1;
				ram_waddr = '0;
				ram_wdata = '{start: cfg.heap_base, len: heap_len};
				cnt_d     = (heap_len != '0) ? CW'(1) : '0;
				state_d   = S_IDLE;
			end
			S_IDLE: begin
				ram_raddr = '0;
				if (in_valid) begin
					op_d        = op;
					size_d      = req_size;
					addr_d      = block_addr;
					idx_d       = '0;
					res_grant_d = '0;
					if (op == OP_FREE) begin
						state_d = S_FCHK;
					end else if (req_size == '0) begin
						res_status_d = ST_ZERO;
						state_d      = S_RESP;
					end else if (cnt_q == '0) begin
						res_status_d = ST_NOSPACE;
						state_d      = S_RESP;
					end else begin
						state_d = S_ASCAN;
					end
				end
			end
			S_ASCAN: begin
				alu_req = '{a: ram_rdata.len, b: size_q, sub: 1'b1};
				if (alu_sum[ADDR_W]) begin
					cur_d        = ram_rdata;
					res_grant_d  = ram_rdata.start;
					res_status_d = ST_OK;
					if (alu_sum[ADDR_W-1:0] == '0) begin
						// exact fit: drop the entry, read of idx+1 is in flight
						if (idx_p1 == cnt_q) begin
							cnt_d   = cnt_m1;
							state_d = S_RESP;
						end else begin
							state_d = S_SHIFT;
						end
					end else begin
						acc_d   = alu_sum[ADDR_W-1:0];
						state_d = S_AUPD;
					end
				end else begin
					idx_d = idx_p1;
					if (idx_p1 == cnt_q) begin
						res_status_d = ST_NOSPACE;
						state_d      = S_RESP;
					end
				end
			end
			S_AUPD: begin
				alu_req   = '{a: cur_q.start, b: size_q, sub: 1'b0};
				ram_we    = 1'b1;
				ram_wdata = '{start: alu_sum[ADDR_W-1:0], len: acc_q};
				state_d   = S_RESP;
			end
			S_FCHK: begin
				alu_req   = '{a: addr_q, b: size_q, sub: 1'b0};
				ram_raddr = '0;
				end_d     = alu_sum[ADDR_W-1:0];
				if ((addr_q == '0) || (size_q == '0) || alu_sum[ADDR_W]) begin
					res_status_d = ST_IGNORED;
					state_d      = S_RESP;
				end else if (cnt_q == '0) begin
					pos_d   = '0;
					state_d = S_FJOIN;
				end else begin
					state_d = S_FSCAN;
				end
			end
			S_FSCAN: begin
				alu_req = '{a: ram_rdata.start, b: addr_q, sub: 1'b1};
				if (alu_sum[ADDR_W]) begin
					cur_d   = ram_rdata;
					pos_d   = idx_q;
					state_d = S_FJOIN;
				end else begin
					prev_d = ram_rdata;
					idx_d  = idx_p1;
					if (idx_p1 == cnt_q) begin
						pos_d   = cnt_q;
						state_d = S_FJOIN;
					end
				end
			end
			S_FJOIN: begin
				alu_req = '{a: prev_q.start, b: prev_q.len, sub: 1'b0};
				jlo_d   = (pos_q != '0) && (alu_sum == {1'b0, addr_q});
				jhi_d   = (pos_q != cnt_q) && (cur_q.start == end_q);
				idx_d   = pos_q;
				state_d = S_FMRG;
			end
			S_FMRG: begin
				alu_req      = '{a: jlo_q ? prev_q.len : cur_q.len, b: size_q, sub: 1'b0};
				res_status_d = ST_OK;
				if (jlo_q && jhi_q) begin
					acc_d   = alu_sum[ADDR_W-1:0];
					state_d = S_FMRG2;
				end else if (jlo_q) begin
					ram_we    = 1'b1;
					ram_waddr = pos_m1[IW-1:0];
					ram_wdata = '{start: prev_q.start, len: alu_sum[ADDR_W-1:0]};
					state_d   = S_RESP;
				end else if (jhi_q) begin
					ram_we    = 1'b1;
					ram_waddr = pos_q[IW-1:0];
					ram_wdata = '{start: addr_q, len: alu_sum[ADDR_W-1:0]};
					state_d   = S_RESP;
				end else if (cnt_q == CNT_MAX) begin
					res_status_d = ST_FULL;
					state_d      = S_RESP;
				end else if (pos_q == cnt_q) begin
					state_d = S_INS;
				end else begin
					idx_d   = cnt_m1;
					state_d = S_UPRD;
				end
			end
			S_FMRG2: begin
				// both neighbors touch: grow the lower one, then drop the upper
				alu_req   = '{a: acc_q, b: cur_q.len, sub: 1'b0};
				ram_we    = 1'b1;
				ram_waddr = pos_m1[IW-1:0];
				ram_wdata = '{start: prev_q.start, len: alu_sum[ADDR_W-1:0]};
				if (pos_p1 == cnt_q) begin
					cnt_d   = cnt_m1;
					state_d = S_RESP;
				end else begin
					state_d = S_SHIFT;
				end
			end
			S_SHIFT: begin
				ram_we    = 1'b1;
				ram_wdata = ram_rdata;
				ram_raddr = idx_p2[IW-1:0];
				idx_d     = idx_p1;
				if (idx_p2 == cnt_q) begin
					cnt_d   = cnt_m1;
					state_d = S_RESP;
				end
			end
			S_UPRD: begin
				ram_raddr = idx_q[IW-1:0];
				state_d   = S_UPWR;
			end
			S_UPWR: begin
				ram_we    = 1'b1;
				ram_waddr = idx_p1[IW-1:0];
				ram_wdata = ram_rdata;
				ram_raddr = idx_m1[IW-1:0];
				if (idx_q == pos_q) begin
					state_d = S_INS;
				end else begin
					idx_d = idx_m1;
				end
			end
			S_INS: begin
				ram_we       = 1'b1;
				ram_waddr    = pos_q[IW-1:0];
				ram_wdata    = '{start: addr_q, len: size_q};
				cnt_d        = cnt_q + CW'(1);
				res_status_d = ST_OK;
				state_d      = S_RESP;
			end
			S_RESP: begin
				if (load_out) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_REBUILD;
			end
		endcase

		if (cfg.rebuild) begin
			state_d = S_REBUILD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_REBUILD;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			out_valid_q <= load_out || (out_valid_q && !out_ready);
		end
	end

	always_ff @(posedge clk) begin
		idx_q        <= idx_d;
		pos_q        <= pos_d;
		op_q         <= op_d;
		size_q       <= size_d;
		addr_q       <= addr_d;
		end_q        <= end_d;
		acc_q        <= acc_d;
		prev_q       <= prev_d;
		cur_q        <= cur_d;
		jlo_q        <= jlo_d;
		jhi_q        <= jhi_d;
		res_grant_q  <= res_grant_d;
		res_status_q <= res_status_d;
		if (load_out) begin
			out_grant_q  <= res_grant_q;
			out_status_q <= res_status_q;
		end
	end

	`FFA_ASSERT(a_cnt_bound, cnt_q <= CNT_MAX, "extent count above table size")
	`FFA_ASSERT_IMP(a_scan_range, (state_q == S_ASCAN) || (state_q == S_FSCAN), idx_q < cnt_q, "scan index past table end")
	`FFA_ASSERT_IMP(a_ins_room, state_q == S_INS, cnt_q < CNT_MAX, "insert into full table")
	`FFA_ASSERT_IMP(a_grant_zero, out_valid_q && (out_status_q != ST_OK), out_grant_q == '0, "nonzero address on refusal")

endmodule

`default_nettype wire

// ===== sv/first_fit_extent_allocator.sv =====
// Top level of the first-fit extent allocator: APB registers and wiring.
// Depends on ffa_pkg, ffa_ctrl, ffa_alu and ffa_ram.
`default_nettype none

// Channel   Dir   Handshake            Word
// -------   ---   ------------------   ------------------------------------
// in        in    in_valid/in_ready    op, req_size, block_addr
// out       out   out_valid/out_ready  grant_addr, status
// apb       in    psel/penable/pready  heap_base at 0x0, heap_size at 0x4
//
// One word at a time. Allocate scans for the first extent long enough and
// shrinks it, or on an exact fit drops it and moves later extents down.
// Free checks the block, scans the extents below block_addr, then grows a
// touching neighbor (if both touch, drops the upper one) or moves extents
// up to open a new entry. The single table RAM and the adder serve every
// step. After reset and after every register write the table is rebuilt
// in S_REBUILD; in_ready stays low meanwhile. A new word is taken while
// the previous result still waits on a stalled out channel.

module first_fit_extent_allocator #(
	parameter int MAX_EXTENTS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// request channel
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              op,
	input  wire ffa_pkg::addr_t    req_size,
	input  wire ffa_pkg::addr_t    block_addr,
	// result channel
	output logic                   out_valid,
	input  wire logic              out_ready,
	output ffa_pkg::addr_t         grant_addr,
	output ffa_pkg::status_t       status,
	// register port
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [2:0]        paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);
	import ffa_pkg::*;

	localparam int IW = $clog2(MAX_EXTENTS);

	addr_t                heap_base_q;
	addr_t                heap_size_q;
	logic                 cfg_wr;
	cfg_t                 cfg;
	alu_req_t             alu_req;
	logic [ADDR_W:0]      alu_sum;
	logic                 ram_we;
	logic [IW-1:0]        ram_waddr;
	logic [IW-1:0]        ram_raddr;
	extent_t              ram_wdata;
	extent_t              ram_rdata;

	// Any completed write rebuilds the table; paddr[2] picks the register
	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;
	assign prdata = paddr[2] ? heap_size_q : heap_base_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_base_q <= '0;
			heap_size_q <= 32'h0001_0000;
		end else if (cfg_wr) begin
			if (paddr[2]) begin
				heap_size_q <= pwdata;
			end else begin
				heap_base_q <= pwdata;
			end
		end
	end

	assign cfg = '{heap_base: heap_base_q, heap_size: heap_size_q, rebuild: cfg_wr};

	// Sequencer: scans, merges and table moves
	ffa_ctrl #(
		.MAX_EXTENTS(MAX_EXTENTS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.req_size   (req_size),
		.block_addr (block_addr),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.grant_addr (grant_addr),
		.status     (status),
		.alu_req    (alu_req),
		.alu_sum    (alu_sum),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata),
		.ram_raddr  (ram_raddr),
		.ram_rdata  (ram_rdata)
	);

	// Single adder shared by the scan compares and the address and length sums
	ffa_alu u_alu (
		.req (alu_req),
		.sum (alu_sum)
	);

	// Extent table, sorted by start address, entries past the count unused
	ffa_ram #(
		.WIDTH($bits(extent_t)),
		.DEPTH(MAX_EXTENTS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

`default_nettype wire

// ===== sim/first_fit_extent_allocator_tb.sv =====
// Self-checking bench for first_fit_extent_allocator: directed words, then random
// allocate/free traffic across several heap settings, checked against a free-list model.
// Depends on ffa_pkg and the RTL of first_fit_extent_allocator.
`default_nettype none

module first_fit_extent_allocator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ffa_pkg::*;

	localparam int MAX_EXT = 16;

	// Register byte addresses on the APB port
	localparam logic [2:0] REG_HEAP_BASE = 3'h0;
	localparam logic [2:0] REG_HEAP_SIZE = 3'h4;

	localparam logic [32:0] ADDR_TOP = 33'h0_FFFF_FFFF;

	// The slowest word, stalled results, sender gaps and the one long receiver hold
	// (LONG_HOLD) all fit inside QUIET_LIMIT. Quiet stretches longer than this mean
	// the block is stuck.
	localparam int QUIET_LIMIT = 3000;
	localparam int LONG_HOLD   = 300;
	localparam int HOLD_AT     = 60;

	localparam int N_DIRECTED = 23;
	localparam int N_PHASES   = 9;

	typedef enum int {EP_FILL, EP_COMB, EP_DRAIN, EP_MIX} episode_e;

	// One expected result word
	typedef struct packed {
		addr_t   grant;
		status_t st;
	} grant_rec_t;

	// A block the bench believes it owns (granted and not yet freed)
	typedef struct packed {
		addr_t lo;
		addr_t len;
	} held_blk_t;

	// Directed word; known = 1 means the expected result is spelled out in the row
	typedef struct packed {
		logic    op;
		addr_t   size;
		addr_t   addr;
		logic    known;
		addr_t   grant;
		status_t st;
	} dir_row_t;

	logic         clk;
	logic         arst_n;
	logic         in_valid;
	logic         in_ready;
	logic         op;
	addr_t        req_size;
	addr_t        block_addr;
	logic         out_valid;
	logic         out_ready;
	addr_t        grant_addr;
	status_t      status;
	logic         psel;
	logic         penable;
	logic         pwrite;
	logic [2:0]   paddr;
	logic [31:0]  pwdata;
	logic [31:0]  prdata;
	logic         pready;

	// Free-list model state
	addr_t        fl_start [MAX_EXT];
	addr_t        fl_len   [MAX_EXT];
	int unsigned  fl_count;
	addr_t        cur_base;
	addr_t        cur_size;

	grant_rec_t   pending_grants [$];
	held_blk_t    held [$];
	addr_t        comb_q [$];

	addr_t        phase_span;
	addr_t        last_free_lo;
	addr_t        last_free_len;
	int           burst_left;
	int           total_words;
	int           n_errors;
	bit           long_hold_req;

	// Directed words, all under the reset heap (base 0, 64 KiB)
	dir_row_t dir_rows [N_DIRECTED] = '{
		'{OP_ALLOC, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_ZERO},
		'{OP_ALLOC, 32'h0001_0001, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, ST_NOSPACE},
		'{OP_ALLOC, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_NOSPACE},
		// first grant lands on address zero
		'{OP_ALLOC, 32'h0000_0040, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_OK},
		'{OP_ALLOC, 32'h0000_0040, 32'h0000_0000, 1'b1, 32'h0000_0040, ST_OK},
		// frees that must be dropped: zero address, zero size, past the top
		'{OP_FREE,  32'h0000_0040, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_IGNORED},
		'{OP_FREE,  32'h0000_0000, 32'h0000_0040, 1'b1, 32'h0000_0000, ST_IGNORED},
		'{OP_FREE,  32'h0000_0001, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, ST_IGNORED},
		'{OP_FREE,  32'h0000_0100, 32'hFFFF_FF00, 1'b1, 32'h0000_0000, ST_IGNORED},
		// ends exactly at the top of the address space
		'{OP_FREE,  32'h0000_00FF, 32'hFFFF_FF00, 1'b0, 32'h0000_0000, ST_OK},
		// touches the extent above it
		'{OP_FREE,  32'h0000_0040, 32'h0000_0040, 1'b0, 32'h0000_0000, ST_OK},
		'{OP_ALLOC, 32'h0000_FFC0, 32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK},
		'{OP_ALLOC, 32'h0000_0100, 32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK},
		'{OP_ALLOC, 32'h0000_00FF, 32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK},
		// table now empty
		'{OP_ALLOC, 32'h0000_0001, 32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK},
		'{OP_FREE,  32'h0000_0010, 32'h0000_1000, 1'b0, 32'h0000_0000, ST_OK},
		'{OP_FREE,  32'h0000_0010, 32'h0000_1020, 1'b0, 32'h0000_0000, ST_OK},
		// closes the hole between two extents
		'{OP_FREE,  32'h0000_0010, 32'h0000_1010, 1'b0, 32'h0000_0000, ST_OK},
		'{OP_FREE,  32'h0000_0010, 32'h0000_0FF0, 1'b0, 32'h0000_0000, ST_OK},
		'{OP_FREE,  32'h0000_0005, 32'h0000_1030, 1'b0, 32'h0000_0000, ST_OK},
		'{OP_FREE,  32'h5555_AAAA, 32'hAAAA_5555, 1'b0, 32'h0000_0000, ST_OK},
		'{OP_ALLOC, 32'h0000_0055, 32'h5555_5555, 1'b0, 32'h0000_0000, ST_OK},
		// overlaps an extent already in the table
		'{OP_FREE,  32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 32'h0000_0000, ST_OK}
	};

	first_fit_extent_allocator #(
		.MAX_EXTENTS(MAX_EXT)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.req_size   (req_size),
		.block_addr (block_addr),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.grant_addr (grant_addr),
		.status     (status),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Free-list model
	// ------------------------------------------------------------------

	// Table after reset or a register write: one extent, clipped at the top
	function automatic void rebuild_free_list();
		logic [32:0] span;
		span = {1'b0, cur_size};
		for (int i = 0; i < MAX_EXT; i++) begin
			fl_start[i] = '0;
			fl_len[i]   = '0;
		end
		if ({1'b0, cur_base} + span > ADDR_TOP)
			span = ADDR_TOP - {1'b0, cur_base};
		fl_start[0] = cur_base;
		fl_len[0]   = span[31:0];
		fl_count    = (span != '0) ? 1 : 0;
	endfunction

	function automatic void drop_extent(input int unsigned pos);
		int unsigned i;
		for (i = pos; i + 1 < fl_count; i++) begin
			fl_start[i] = fl_start[i+1];
			fl_len[i]   = fl_len[i+1];
		end
		fl_count--;
		fl_start[fl_count] = '0;
		fl_len[fl_count]   = '0;
	endfunction

	// First fit: take the low part of the first extent that is long enough
	function automatic status_t predict_alloc(input addr_t sz, output addr_t grant);
		int unsigned i;
		grant = '0;
		if (sz == '0)
			return ST_ZERO;
		for (i = 0; i < fl_count; i++) begin
			if (fl_len[i] >= sz) begin
				grant = fl_start[i];
				if (fl_len[i] == sz)
					drop_extent(i);
				else begin
					fl_start[i] += sz;
					fl_len[i]   -= sz;
				end
				return ST_OK;
			end
		end
		return ST_NOSPACE;
	endfunction

	// Insert by address, merging only on exact contact with either neighbor
	function automatic status_t predict_free(input addr_t at, input addr_t sz);
		logic [32:0] stop;
		int unsigned pos;
		int unsigned i;
		logic        join_lo;
		logic        join_hi;
		stop = {1'b0, at} + {1'b0, sz};
		if (at == '0 || sz == '0 || stop > ADDR_TOP)
			return ST_IGNORED;
		pos = 0;
		while (pos < fl_count && fl_start[pos] < at)
			pos++;
		join_lo = 1'b0;
		join_hi = 1'b0;
		if (pos > 0)
			join_lo = ({1'b0, fl_start[pos-1]} + {1'b0, fl_len[pos-1]}) == {1'b0, at};
		if (pos < fl_count)
			join_hi = {1'b0, fl_start[pos]} == stop;
		if (join_lo) begin
			fl_len[pos-1] += sz;
			if (join_hi) begin
				fl_len[pos-1] += fl_len[pos];
				drop_extent(pos);
			end
			return ST_OK;
		end
		if (join_hi) begin
			fl_start[pos] = at;
			fl_len[pos]  += sz;
			return ST_OK;
		end
		if (fl_count >= MAX_EXT)
			return ST_FULL;
		for (i = fl_count; i > pos; i--) begin
			fl_start[i] = fl_start[i-1];
			fl_len[i]   = fl_len[i-1];
		end
		fl_start[pos] = at;
		fl_len[pos]   = sz;
		fl_count++;
		return ST_OK;
	endfunction

	// ------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------

	// Sends one word in bursts with random gaps, waits for the handshake, then
	// runs the model on the accepted word and queues the result it expects.
	task automatic issue_request(input logic o, input addr_t sz, input addr_t ad,
			input logic known, input addr_t known_grant, input status_t known_st,
			output addr_t g, output status_t s);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
			repeat (gap) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid   <= 1'b1;
		op         <= o;
		req_size   <= sz;
		block_addr <= ad;
		do @(posedge clk); while (!in_ready);
		if (o == OP_ALLOC)
			s = predict_alloc(sz, g);
		else begin
			g = '0;
			s = predict_free(ad, sz);
		end
		pending_grants.push_back(known ? grant_rec_t'{known_grant, known_st} :
			grant_rec_t'{g, s});
		total_words++;
		if (total_words == HOLD_AT)
			long_hold_req = 1'b1;
	endtask

	// Lower valid and let every outstanding result come back
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_grants.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// APB write followed by a read-back of the same register
	task automatic program_reg(input logic [2:0] reg_addr, input addr_t value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= reg_addr;
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (reg_addr == REG_HEAP_BASE)
			cur_base = value;
		else
			cur_size = value;
		rebuild_free_list();
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== value) begin
			$error("prdata at 0x%0h: expected %h, got %h", reg_addr, value, prdata);
			n_errors++;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Mostly small requests scaled to the heap, a few large or wild ones
	function automatic addr_t pick_alloc_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 3)
			return $urandom;
		if (r < 8 || phase_span < 48)
			return $urandom_range(1, (phase_span < 64) ? 64 : phase_span);
		return $urandom_range(1, phase_span / 48);
	endfunction

	// Random traffic under one heap setting. Episodes: fill the heap, free every
	// other block in address order (builds a comb of holes until the table is
	// full), drain in random order with partial frees, or a plain mix. A small
	// share of words is noise: zero sizes, bad addresses, wild fields, double frees.
	task automatic run_random_phase(input int n_words);
		episode_e  ep;
		int        counted;
		int        ep_left;
		int        ep_no;
		int        free_idx;
		int        free_kind;   // 1 whole block, 2 low part, 3 high part
		int        j;
		addr_t     cut;
		addr_t     victim;
		logic      o;
		addr_t     sz;
		addr_t     ad;
		addr_t     g;
		status_t   s;
		counted = 0;
		ep_left = 0;
		ep_no   = 0;
		ep      = EP_FILL;
		held.delete();
		comb_q.delete();
		while (counted < n_words) begin
			if (ep_left == 0) begin
				if (ep_no == 0)
					ep = EP_FILL;
				else if (ep_no == 1)
					ep = EP_COMB;
				else
					ep = episode_e'($urandom_range(0, 3));
				case (ep)
					EP_FILL: begin
						ep_left = (ep_no == 0) ? 36 : $urandom_range(4, 40);
					end
					EP_COMB: begin
						comb_q.delete();
						for (j = 0; j < held.size(); j += 2)
							comb_q.push_back(held[j].lo);
						ep_left = comb_q.size() + 1;
					end
					EP_DRAIN: ep_left = $urandom_range(4, held.size() + 4);
					default:  ep_left = $urandom_range(16, 64);
				endcase
				ep_no++;
			end
			ep_left--;

			free_idx  = -1;
			free_kind = 0;
			cut       = '0;
			o         = OP_ALLOC;
			sz        = pick_alloc_size();
			ad        = $urandom;   // don't care on allocate

			if ($urandom_range(0, 99) < 8) begin
				case ($urandom_range(0, 5))
					0: sz = '0;
					1: begin
						o  = OP_FREE;
						ad = '0;
						sz = $urandom;
					end
					2: begin
						o  = OP_FREE;
						sz = '0;
					end
					3: begin
						// runs one or more bytes past the top
						o  = OP_FREE;
						ad = $urandom_range(32'hFFFF_0000, 32'hFFFF_FFFF);
						sz = 32'hFFFF_FFFF - ad + 1 + $urandom_range(0, 1000);
					end
					4: begin
						o  = $urandom_range(0, 1);
						sz = $urandom;
					end
					default: begin
						o  = OP_FREE;
						ad = last_free_lo;
						sz = last_free_len;
					end
				endcase
			end else begin
				case (ep)
					EP_FILL: ;
					EP_COMB: begin
						if (comb_q.size() != 0) begin
							victim = comb_q.pop_front();
							for (j = 0; j < held.size() && free_idx < 0; j++)
								if (held[j].lo == victim)
									free_idx = j;
							free_kind = 1;
						end
					end
					default: begin
						if (held.size() != 0 && (ep == EP_DRAIN || $urandom_range(0, 1))) begin
							free_idx  = $urandom_range(0, held.size() - 1);
							free_kind = 1;
							if (held[free_idx].len > 1 && $urandom_range(0, 3) == 0) begin
								free_kind = $urandom_range(2, 3);
								cut = $urandom_range(1, held[free_idx].len - 1);
							end
						end else if (held.size() == 0 && $urandom_range(0, 1)) begin
							// nothing owned: hand the block a fresh extent
							o  = OP_FREE;
							ad = cur_base + $urandom_range(1, 16'hFFFF);
							sz = $urandom_range(1, 64);
						end
					end
				endcase
			end

			if (free_idx >= 0) begin
				o = OP_FREE;
				case (free_kind)
					2: begin
						ad = held[free_idx].lo;
						sz = cut;
					end
					3: begin
						ad = held[free_idx].lo + cut;
						sz = held[free_idx].len - cut;
					end
					default: begin
						ad = held[free_idx].lo;
						sz = held[free_idx].len;
					end
				endcase
			end

			issue_request(o, sz, ad, 1'b0, '0, ST_OK, g, s);

			// Keep the owned list in step with what the block accepted
			if (s == ST_OK) begin
				if (o == OP_ALLOC) begin
					j = 0;
					while (j < held.size() && held[j].lo < g)
						j++;
					held.insert(j, held_blk_t'{g, sz});
				end else begin
					last_free_lo  = ad;
					last_free_len = sz;
					if (free_idx >= 0) begin
						case (free_kind)
							2: begin
								held[free_idx].lo  += cut;
								held[free_idx].len -= cut;
							end
							3: held[free_idx].len = cut;
							default: held.delete(free_idx);
						endcase
					end
				end
			end
			if (s != ST_IGNORED)
				counted++;
		end
	endtask

	// ------------------------------------------------------------------
	// Result side
	// ------------------------------------------------------------------

	// Receiver: switches among random stall patterns, from always ready to mostly
	// stalled. Once, on request, it holds out_ready low while words keep coming,
	// so the block backs up and drops in_ready.
	initial begin
		int       mode_left;
		int       mode;
		logic [7:0] pat;
		out_ready = 1'b0;
		mode_left = 0;
		mode      = 0;
		pat       = 8'hFF;
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
			end else begin
				if (mode_left == 0) begin
					mode_left = $urandom_range(8, 80);
					mode      = $urandom_range(0, 3);
					pat       = $urandom;
				end
				mode_left--;
				pat = {pat[6:0], pat[7]};
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= $urandom_range(0, 1);
					2: out_ready <= pat[0];
					default: out_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// Each result word is matched against the oldest expectation
	always @(posedge clk) begin
		grant_rec_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_grants.size() == 0) begin
				$error("unexpected result word: grant_addr %h, status %0d", grant_addr, status);
				n_errors++;
			end else begin
				want = pending_grants.pop_front();
				if (grant_addr !== want.grant) begin
					$error("grant_addr: expected %h, got %h", want.grant, grant_addr);
					n_errors++;
				end
				if (status !== want.st) begin
					$error("status: expected %0d, got %0d", want.st, status);
					n_errors++;
				end
			end
		end
	end

	// Watchdog: ends the run after too many cycles with no handshake on either side
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Mismatches found");
		$finish;
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		addr_t   ph_base  [N_PHASES];
		addr_t   ph_size  [N_PHASES];
		int      ph_words [N_PHASES];
		addr_t   g;
		status_t s;

		arst_n        = 1'b0;
		in_valid      = 1'b0;
		op            = OP_ALLOC;
		req_size      = '0;
		block_addr    = '0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = REG_HEAP_BASE;
		pwdata        = '0;
		burst_left    = 0;
		total_words   = 0;
		n_errors      = 0;
		long_hold_req = 1'b0;
		last_free_lo  = '0;
		last_free_len = '0;

		// Reset heap: base 0, 64 KiB
		cur_base = '0;
		cur_size = 32'h0001_0000;
		rebuild_free_list();
		phase_span = fl_len[0];

		// Heap settings: a mid-sized heap, a high one, one clipped at the top of the address
		// space, one that ends exactly there, two empty ones, a tiny one and two random ones
		ph_base  = '{32'h0000_1000, 32'h8000_0000, 32'hFFFF_0000, 32'h0000_0000,
			32'hFFFF_FFFF, 32'h0000_0100, 32'h0000_0040, $urandom, $urandom};
		ph_size  = '{32'h0000_8000, 32'h0100_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'h0000_0010, 32'h0000_0000, 32'h0000_0100,
			$urandom_range(32'h100, 32'h10_0000), $urandom_range(32'h100, 32'h10_0000)};
		ph_words = '{165, 165, 165, 165, 60, 60, 150, 170, 170};

		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < N_DIRECTED; i++)
			issue_request(dir_rows[i].op, dir_rows[i].size, dir_rows[i].addr,
				dir_rows[i].known, dir_rows[i].grant, dir_rows[i].st, g, s);

		// Random traffic on the reset heap first; the table is rebuilt so the
		// owned-block list starts clean
		drain_results();
		program_reg(REG_HEAP_SIZE, 32'h0001_0000);
		run_random_phase(165);

		for (int p = 0; p < N_PHASES; p++) begin
			drain_results();
			program_reg(REG_HEAP_BASE, ph_base[p]);
			program_reg(REG_HEAP_SIZE, ph_size[p]);
			phase_span = (fl_count != 0) ? fl_len[0] : '0;
			run_random_phase(ph_words[p]);
		end

		drain_results();
		repeat (40) @(posedge clk);
		if (n_errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+sv
sv/ffa_pkg.sv
sv/ffa_ram.sv
sv/ffa_alu.sv
sv/ffa_ctrl.sv
sv/first_fit_extent_allocator.sv
sim/first_fit_extent_allocator_tb.sv
